>>> src/sfda_pkg.sv
// Shared constants and the CRC helper function for the sensor frame deframer/averager.
// No dependencies; imported by every module of the block.
`default_nettype none
package sfda_pkg;

    localparam logic [7:0] SYNC_MARK = 8'hAA;
    localparam logic [7:0] CRC_POLY  = 8'h8C;
    localparam int FRAME_BYTES = 12;

    localparam logic [1:0] REG_PERIOD  = 2'd0;
    localparam logic [1:0] REG_INVERSE = 2'd1;
    localparam logic [1:0] REG_LIMIT   = 2'd2;

    // One byte of the reflected CRC-8 (eight dependent shift steps on 8 bits).
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> src/sensor_frame_deframer_averager.sv
// Top level of the sensor frame deframer and block averager.
// Depends on sfda_pkg, sfda_float_check and sfda_avg_unit.
//
// Usage: bytes of the sensor stream arrive as words on the s_axis channel
// (one byte per word). Once twelve bytes are in the window and it starts
// with the sync byte, the CRC-8 of bytes 1..10 is worked one byte per cycle
// and compared, then both floats are judged. An accepted frame updates the
// latest values and adds them, one slot per cycle, into the running sums.
// At the end of a period each slot's sum goes through the shared multiplier
// and, from the second period on, is presented on m_axis; the sequencer
// waits on m_axis_tready for each word, so a stalled receiver holds the
// block for as long as it stalls.
// Bytes that only fill the window or fail the sync check are taken back to
// back. A window that passes the sync check keeps s_axis_tready low until
// the sequencer is back in idle: through the CRC check, the float judgement
// and, for an accepted frame, the summing and any period end.
// Configuration words are taken on the cfg channel at any time and must
// only be written while idle. Synchronous reset clears the window, sums,
// counters and registers to their reset values; no clearing pass is needed.
`default_nettype none
module sensor_frame_deframer_averager
    import sfda_pkg::*;
#(
    parameter int NUM_VALUES = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [3:0] value_index, [34:4] average_value,
                                             // [50:35] reject_count, zero fill
    output logic             m_axis_tlast,   // last_of_run
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int IW = $clog2(NUM_VALUES);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CRC  = 7'b0000010,
        ST_CONV = 7'b0000100,
        ST_JUDG = 7'b0001000,
        ST_SUM  = 7'b0010000,
        ST_AVG  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    logic [15:0] r_period;
    logic [31:0] r_inv;
    logic [14:0] r_limit;
    logic [7:0]  r_win [FRAME_BYTES];
    logic [3:0]  r_skip;
    logic [31:0] r_latest [NUM_VALUES];
    logic [47:0] r_sums [NUM_VALUES];
    logic [15:0] r_frames;
    logic        r_warm;
    logic [15:0] r_rejects;
    logic [7:0]  r_crc;
    logic [3:0]  r_cnt;
    logic [IW-1:0] r_slot;
    logic        r_emit;
    logic        r_out_valid;
    logic [3:0]  r_out_idx;
    logic [30:0] r_out_avg;
    logic        r_out_last;

    logic        ok0, ok1;
    logic [31:0] fix0, fix1;
    logic        avg_done;
    logic [30:0] avg_val;
    logic        take;
    logic [3:0]  hi_slot;

    assign take = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign hi_slot = r_win[2][7:4];

    sfda_float_check #(.FRAC_BITS(FRAC_BITS)) u_f0 (
        .i_clk(i_clk),
        .i_bits({r_win[6], r_win[5], r_win[4], r_win[3]}),
        .i_limit(r_limit), .o_ok(ok0), .o_fixed(fix0));
    sfda_float_check #(.FRAC_BITS(FRAC_BITS)) u_f1 (
        .i_clk(i_clk),
        .i_bits({r_win[10], r_win[9], r_win[8], r_win[7]}),
        .i_limit(r_limit), .o_ok(ok1), .o_fixed(fix1));

    sfda_avg_unit u_avg (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_state == ST_AVG && !r_emit),
        .i_sum(r_sums[r_slot]), .i_inv(r_inv),
        .o_done(avg_done), .o_avg(avg_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd600;
            r_inv    <= 32'd7158278;
            r_limit  <= 15'd10000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PERIOD:  r_period <= cfg_data[15:0];
                REG_INVERSE: r_inv    <= cfg_data;
                REG_LIMIT:   r_limit  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_skip  <= 4'd11;
            r_frames <= '0;
            r_warm  <= 1'b0;
            r_rejects <= '0;
            r_out_valid <= 1'b0;
            r_emit <= 1'b0;
            r_cnt <= '0;
            r_slot <= '0;
            r_crc <= '0;
            for (int i = 0; i < FRAME_BYTES; i++) r_win[i] <= '0;
            for (int i = 0; i < NUM_VALUES; i++) begin
                r_latest[i] <= '0;
                r_sums[i] <= '0;
            end
        end else begin
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        for (int i = 0; i < FRAME_BYTES - 1; i++) r_win[i] <= r_win[i+1];
                        r_win[FRAME_BYTES-1] <= s_axis_tdata;
                        if (r_skip != 4'd0) begin
                            r_skip <= r_skip - 4'd1;
                        end else if (r_win[1] == SYNC_MARK) begin
                            r_crc <= '0;
                            r_cnt <= 4'd1;
                            r_state <= ST_CRC;
                        end
                    end
                end
                ST_CRC: begin
                    r_crc <= crc8_byte(r_crc, r_win[r_cnt]);
                    if (r_cnt == 4'd10) r_state <= ST_CONV;
                    r_cnt <= r_cnt + 4'd1;
                end
                ST_CONV: begin
                    r_state <= (r_crc == r_win[11]) ? ST_JUDG : ST_IDLE;
                end
                ST_JUDG: begin
                    if (!(ok0 && ok1)) begin
                        if (r_rejects != 16'hFFFF) r_rejects <= r_rejects + 16'd1;
                        r_state <= ST_IDLE;
                    end else begin
                        // A slot nibble of zero lets the second float replace the first.
                        if (hi_slot != 4'd0) r_latest[0] <= fix0;
                        if ({1'b0, hi_slot} < 5'(NUM_VALUES)) begin
                            r_latest[hi_slot[IW-1:0]] <= fix1;
                        end
                        r_skip <= 4'd11;
                        r_slot <= '0;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_sums[r_slot] <= r_sums[r_slot] + {{16{r_latest[r_slot][31]}}, r_latest[r_slot]};
                    if (r_slot == IW'(NUM_VALUES - 1)) begin
                        r_slot <= '0;
                        if (r_frames + 16'd1 >= r_period) begin
                            r_frames <= '0;
                            r_emit <= 1'b0;
                            r_state <= ST_AVG;
                        end else begin
                            r_frames <= r_frames + 16'd1;
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                ST_AVG: begin
                    // r_emit marks the unit busy with the current slot.
                    r_emit <= !avg_done;
                    if (avg_done) begin
                        r_sums[r_slot] <= '0;
                        if (r_warm) begin
                            r_out_valid <= 1'b1;
                            r_out_idx <= 4'(r_slot);
                            r_out_avg <= avg_val;
                            r_out_last <= (r_slot == IW'(NUM_VALUES - 1));
                            r_state <= ST_OUT;
                        end else if (r_slot == IW'(NUM_VALUES - 1)) begin
                            r_warm <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        if (r_slot == IW'(NUM_VALUES - 1)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                            r_state <= ST_AVG;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_rejects, r_out_avg, r_out_idx};
    assign m_axis_tlast  = r_out_last;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_out_valid) else $error("input taken while output pending");
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == ST_OUT) else $error("output outside ST_OUT");
    a_warm_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_warm) else $error("output before warm-up");
endmodule
`default_nettype wire

>>> src/sfda_float_check.sv
// Float range check and float-to-fixed conversion for one IEEE single.
// Depends on sfda_pkg. Registered result; one conversion in flight at a time.
`default_nettype none
module sfda_float_check
    import sfda_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_bits,
    input  wire logic [14:0] i_limit,
    output logic             o_ok,
    output logic [31:0]      o_fixed
);
    logic [7:0]  e;
    logic [23:0] m;
    logic        neg;
    logic signed [9:0] ex;
    logic signed [9:0] t;
    logic [39:0] big;
    logic [8:0]  s;
    logic [23:0] ip;
    logic        fr;
    logic        ok;
    logic [55:0] mag;
    logic [31:0] fixed;

    always_comb begin
        e   = i_bits[30:23];
        neg = i_bits[31];
        m   = {1'b0, i_bits[22:0]};
        if (e == 8'd0) begin
            ex = -10'sd149;
        end else begin
            m[23] = 1'b1;
            ex = $signed({2'b00, e}) - 10'sd150;
        end
        ok  = (e != 8'hFF);
        big = '0;
        s   = '0;
        ip  = '0;
        fr  = 1'b0;
        if (m != 24'd0) begin
            if (ex >= 0) begin
                big = {16'd0, m} << ex[3:0];
                if (ex > 10'sd15) begin
                    ok = 1'b0;
                end else if (big > {25'd0, i_limit}) begin
                    ok = 1'b0;
                end
            end else begin
                s  = 9'(-ex);
                ip = (s >= 9'd32) ? 24'd0 : (m >> s[4:0]);
                fr = (s >= 9'd32) ? 1'b1 : ((m & ((24'd1 << s[4:0]) - 24'd1)) != 24'd0);
                if (ip > {9'd0, i_limit} || (ip == {9'd0, i_limit} && fr)) begin
                    ok = 1'b0;
                end
            end
        end
        t = ex + 10'(FRAC_BITS);
        if (t >= 0) begin
            mag = (t > 10'sd32) ? {56{1'b1}} : ({32'd0, m} << t[5:0]);
        end else begin
            mag = (-t >= 10'sd32) ? 56'd0 : {32'd0, m >> 5'(-t)};
        end
        if (neg) begin
            fixed = (mag > 56'h80000000) ? 32'h80000000 : (32'd0 - mag[31:0]);
        end else begin
            fixed = (mag > 56'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_ok    <= ok;
        o_fixed <= fixed;
    end
endmodule
`default_nettype wire

>>> src/sfda_avg_unit.sv
// Shared averaging unit: sum magnitude times Q0.32 reciprocal, in 16-bit halves.
// Depends on sfda_pkg. The magnitude, the low and high products and the result are registered in turn.
`default_nettype none
module sfda_avg_unit
    import sfda_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_sum,
    input  wire logic [31:0] i_inv,
    output logic             o_done,
    output logic [30:0]      o_avg
);
    logic        r_neg;
    logic [47:0] r_mag;
    logic [2:0]  r_step;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [15:0] factor;
    logic [63:0] prod;
    logic [63:0] q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= {r_step[1:0], i_start};
        end
    end

    // A single 48x16 multiplier takes the low half of the reciprocal first,
    // then the high half on the next cycle.
    assign factor = r_step[0] ? i_inv[15:0] : i_inv[31:16];
    assign prod   = {16'd0, r_mag} * {48'd0, factor};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_sum[47];
            r_mag <= i_sum[47] ? (48'd0 - i_sum) : i_sum;
        end
        if (r_step[0]) r_lo <= prod;
        if (r_step[1]) r_hi <= prod;
    end

    assign q = (r_hi + (r_lo >> 16)) >> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_step[2];
        end
        if (r_step[2]) begin
            if (r_neg) o_avg <= 31'(32'd0 - ((q > 64'h40000000) ? 32'h40000000 : q[31:0]));
            else       o_avg <= (q > 64'h3FFFFFFF) ? 31'h3FFFFFFF : q[30:0];
        end
    end
endmodule
`default_nettype wire

>>> tb/sensor_frame_deframer_averager_test.sv
// Self-checking testbench for sensor_frame_deframer_averager: feeds sensor frames
// and noise as bytes, predicts the averaged words and compares them on m_axis.
// Depends on sfda_pkg and the block's RTL.
`timescale 1ns / 1ps
module sensor_frame_deframer_averager_test;
    import sfda_pkg::*;

    localparam int SLOTS = 12;
    // Index past the last register; the block must ignore writes to it.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef logic [7:0] t_frame [12];

    typedef struct packed {
        logic [3:0]  slot;
        logic [30:0] average;
        logic [15:0] rejects;
        logic        last;
    } t_avg_word;

    // One directed frame: header bytes, both floats, and a CRC corruption mask.
    typedef struct {
        logic [7:0]  sync;
        logic [7:0]  tag;
        logic [7:0]  slot_byte;
        logic [31:0] f0;
        logic [31:0] f1;
        logic [7:0]  crc_flip;
    } t_frame_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    sensor_frame_deframer_averager uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state, mirroring what the block keeps.
    logic [15:0] period_len;
    logic [31:0] inv_period;
    logic [14:0] max_magnitude;
    logic [7:0]  window [12];
    int          fill_left;
    logic [31:0] latest [SLOTS];
    logic [47:0] sums [SLOTS];
    logic [15:0] frame_count;
    bit          warm;
    logic [15:0] reject_tally;

    t_avg_word   pending_avgs [$];
    int          fail_count = 0;
    bit          no_gaps = 1'b0;

    // Reflected CRC-8 (poly 0x8C, init 0) over bytes 1..10 of a frame.
    function automatic logic [7:0] frame_crc(input t_frame f);
        logic [7:0] c;
        c = 8'd0;
        for (int i = 1; i <= 10; i++) begin
            c = c ^ f[i];
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
            end
        end
        return c;
    endfunction

    // Range check and conversion to Q15.16; returns 0 when the frame must be rejected.
    function automatic bit float_to_fixed(input logic [31:0] bits, output logic [31:0] fixed);
        int unsigned     e;
        int unsigned     m;
        bit              neg;
        int              ex;
        int              t;
        int unsigned     s;
        longint unsigned mag;
        int unsigned     ip;
        bit              fr;
        e = bits[30:23];
        m = bits[22:0];
        neg = bits[31];
        fixed = 32'd0;
        if (e == 255) return 1'b0;  // NaN and infinity never pass
        if (e == 0) begin
            ex = -149;
        end else begin
            m = m | 32'h800000;
            ex = int'(e) - 150;
        end
        if (m != 0) begin
            if (ex >= 0) begin
                if (ex > 15) return 1'b0;
                if ((longint'(m) << ex) > longint'(max_magnitude)) return 1'b0;
            end else begin
                s = -ex;
                ip = (s >= 32) ? 0 : (m >> s);
                fr = (s >= 32) ? 1'b1 : ((m & ((32'd1 << s) - 1)) != 0);
                if (ip > max_magnitude || (ip == max_magnitude && fr)) return 1'b0;
            end
        end
        t = ex + 16;
        if (t >= 0) begin
            mag = longint'(m) << t;
        end else begin
            s = -t;
            mag = (s >= 32) ? 0 : longint'(m >> s);
        end
        if (neg) begin
            if (mag > 64'h80000000) mag = 64'h80000000;
            fixed = 32'd0 - mag[31:0];
        end else begin
            if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
            fixed = mag[31:0];
        end
        return 1'b1;
    endfunction

    // Sum times the Q0.32 reciprocal, truncated toward zero and saturated to 31 bits.
    function automatic logic [30:0] scaled_average(input logic [47:0] sum);
        logic [47:0]     mag48;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned q;
        logic [31:0]     negq;
        mag48 = sum[47] ? (48'd0 - sum) : sum;
        hi = longint'(mag48) * longint'(inv_period[31:16]);
        lo = longint'(mag48) * longint'(inv_period[15:0]);
        q = (hi + (lo >> 16)) >> 16;
        if (sum[47]) begin
            if (q > 64'h40000000) q = 64'h40000000;
            negq = 32'd0 - q[31:0];
            return negq[30:0];
        end
        if (q > 64'h3FFFFFFF) q = 64'h3FFFFFFF;
        return q[30:0];
    endfunction

    task automatic predictor_reset();
        period_len = 16'd600;
        inv_period = 32'd7158278;
        max_magnitude = 15'd10000;
        foreach (window[i]) window[i] = 8'd0;
        fill_left = 11;
        for (int i = 0; i < SLOTS; i++) begin
            latest[i] = 32'd0;
            sums[i] = 48'd0;
        end
        frame_count = 16'd0;
        warm = 1'b0;
        reject_tally = 16'd0;
    endtask

    // Advances the predictor by one accepted byte and queues any averages it ends.
    task automatic predict_byte(input logic [7:0] b);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] f0bits;
        logic [31:0] f1bits;
        int          slot;
        t_avg_word   w;
        for (int i = 0; i < 11; i++) window[i] = window[i + 1];
        window[11] = b;
        if (fill_left > 0) begin
            fill_left--;
            return;
        end
        if (window[0] != SYNC_MARK || frame_crc(window) != window[11]) return;
        f0bits = {window[6], window[5], window[4], window[3]};
        f1bits = {window[10], window[9], window[8], window[7]};
        if (!float_to_fixed(f0bits, v0) || !float_to_fixed(f1bits, v1)) begin
            if (reject_tally != 16'hFFFF) reject_tally++;
            return;
        end
        latest[0] = v0;
        slot = window[2][7:4];
        if (slot < SLOTS) latest[slot] = v1;  // slots 12..15 drop the second float
        fill_left = 11;
        for (int i = 0; i < SLOTS; i++) begin
            sums[i] = sums[i] + {{16{latest[i][31]}}, latest[i]};
        end
        frame_count++;
        if (frame_count >= period_len) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (warm) begin
                    w.slot = i[3:0];
                    w.average = scaled_average(sums[i]);
                    w.rejects = reject_tally;
                    w.last = (i == SLOTS - 1);
                    pending_avgs.push_back(w);
                end
                sums[i] = 48'd0;
            end
            frame_count = 16'd0;
            warm = 1'b1;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_byte(b);
    endtask

    task automatic send_frame(input t_frame f);
        for (int i = 0; i < 12; i++) send_byte(f[i]);
    endtask

    function automatic t_frame build_frame(input logic [7:0] sync, input logic [7:0] tag,
                                           input logic [7:0] slot_byte, input logic [31:0] f0,
                                           input logic [31:0] f1, input logic [7:0] crc_flip);
        t_frame f;
        f[0] = sync;
        f[1] = tag;
        f[2] = slot_byte;
        for (int i = 0; i < 4; i++) begin
            f[3 + i] = f0[8 * i +: 8];
            f[7 + i] = f1[8 * i +: 8];
        end
        f[11] = frame_crc(f) ^ crc_flip;
        return f;
    endfunction

    // Mostly in-range floats, with some large, subnormal, special and raw patterns.
    function automatic logic [31:0] pick_float();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 10))
            7:       r[30:23] = 8'($urandom_range(140, 150));
            8:       r[30:23] = 8'd0;
            9:       ;
            10:      r = 32'd0;
            default: r[30:23] = 8'($urandom_range(100, 139));
        endcase
        return r;
    endfunction

    // Holds the stream until every expected word is out, then lets any frame in flight finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_avgs.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_PERIOD:  period_len = value[15:0];
            REG_INVERSE: inv_period = value;
            REG_LIMIT:   max_magnitude = value[14:0];
            default:     ;
        endcase
    endtask

    // Directed frames under reset limits: range edges, specials, slot routing, bad CRC.
    t_frame_row directed [7] = '{
        '{8'hAA, 8'h00, 8'h00, 32'h00000000, 32'h00000000, 8'h00},  // zeros, slot 0 overwrite
        '{8'hAA, 8'hFF, 8'hB0, 32'h461C4000, 32'hC61C4000, 8'h00},  // +/-10000.0, slot 11
        '{8'hAA, 8'h12, 8'h10, 32'h461C4200, 32'h3F800000, 8'h00},  // 10000.5 rejected
        '{8'hAA, 8'h34, 8'h20, 32'h7FC00000, 32'hFF800000, 8'h00},  // NaN and -infinity
        '{8'hAA, 8'h78, 8'h4F, 32'h00000001, 32'h80000000, 8'h00},  // subnormal, -0.0
        '{8'hAA, 8'h9A, 8'hC0, 32'h40490FDB, 32'h42C80000, 8'h00},  // slot 12 dropped
        '{8'hAA, 8'hDE, 8'h50, 32'h3F800000, 32'h40000000, 8'h01}   // CRC mismatch
    };

    // Register settings walked by the random phases: {period, inverse, limit}.
    logic [31:0] settings [3][3] = '{
        '{32'd1,     32'hFFFFFFFF, 32'd32767},
        '{32'd0,     32'h80000000, 32'd10000},
        '{32'd2,     32'd4294967,  32'd32767}
    };

    // Result side: random stalls per word, checked against the oldest expectation.
    initial begin
        t_avg_word got;
        t_avg_word want;
        int        stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 12);
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.slot = m_axis_tdata[3:0];
            got.average = m_axis_tdata[34:4];
            got.rejects = m_axis_tdata[50:35];
            got.last = m_axis_tlast;
            if (pending_avgs.size() == 0) begin
                $error("unexpected word: slot %0d average %0h", got.slot, got.average);
                fail_count++;
            end else begin
                want = pending_avgs.pop_front();
                if (got.slot !== want.slot) begin
                    $error("value_index: expected %0d, got %0d", want.slot, got.slot);
                    fail_count++;
                end
                if (got.average !== want.average) begin
                    $error("average_value: expected %0h, got %0h", want.average, got.average);
                    fail_count++;
                end
                if (got.rejects !== want.rejects) begin
                    $error("reject_count: expected %0d, got %0d", want.rejects, got.rejects);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: directed frames, then random phases with a register change between them.
    initial begin
        t_frame f;
        predictor_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A one-frame period makes every accepted directed frame end a period.
        write_reg(REG_PERIOD, 32'd1);
        foreach (directed[r]) begin
            f = build_frame(directed[r].sync, directed[r].tag, directed[r].slot_byte,
                            directed[r].f0, directed[r].f1, directed[r].crc_flip);
            send_frame(f);
        end
        drain();
        // Index 3 addresses no register, so nothing may change.
        write_reg(REG_UNUSED, 32'd1);

        foreach (settings[p]) begin
            write_reg(REG_PERIOD, settings[p][0]);
            write_reg(REG_INVERSE, settings[p][1]);
            write_reg(REG_LIMIT, settings[p][2]);
            no_gaps = (p % 3 == 2);
            case ($urandom_range(0, 7))
                0: repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
                1: send_frame(build_frame(SYNC_MARK, 8'($urandom), 8'($urandom),
                                          pick_float(), pick_float(),
                                          8'($urandom_range(1, 255))));
                default: send_frame(build_frame(SYNC_MARK, 8'($urandom), 8'($urandom),
                                                pick_float(), pick_float(), 8'h00));
            endcase
            drain();
        end

        if (fail_count == 0) begin
            $display("sensor_frame_deframer_averager_test: clean");
        end else begin
            $display("sensor_frame_deframer_averager_test: errors");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("sensor_frame_deframer_averager_test: errors");
        $finish;
    end

endmodule
